// ===== rtl/epcg_pkg.sv =====
`timescale 1ns / 1ps

package epcg_pkg;

	// Fixed field widths
	localparam int START_W = 48;
	localparam int FADE_W  = 24;
	localparam int CFG_W   = 48;
	localparam int CFG_AW  = 2;
	localparam int OUT_W   = 16;

	// Progress t is Q0.16, one extra bit to hold exactly one
	localparam int T_BITS = 16;
	localparam logic [T_BITS:0] T_ONE  = 17'h10000;
	localparam logic [T_BITS:0] T_HALF = 17'h08000;
	localparam logic [T_BITS:0] T_LOW  = 17'd6554;
	localparam logic [T_BITS:0] T_HIGH = 17'd58982;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_AW-1:0] {
		REG_ARMED,
		REG_START,
		REG_FADE,
		REG_SEGMENT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE,   // not armed or before start
		MODE_JUMP,   // zero fade length
		MODE_DONE,   // fade finished, t = one
		MODE_RAMP    // inside the fade, t from divider
	} mode_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
	} ctl_t;

	typedef struct packed {
		logic [OUT_W-1:0] src;
		logic [OUT_W-1:0] dst;
		logic [OUT_W-1:0] mid;
		logic             active;
		logic             done;
	} res_t;

	// sin(x) for x in Q30, Taylor series to x^17, rounded to Q.frac and
	// clamped to unity. Elaboration only.
	function automatic longint unsigned sine_gain(input longint unsigned x,
		input int unsigned frac);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned s;
		longint unsigned g;
		longint unsigned unity;
		longint          sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + longint'(term);
		s     = (sum < 0) ? 64'd0 : longint'(sum);
		g     = (s + (64'd1 << (29 - frac))) >> (30 - frac);
		unity = 64'd1 << frac;
		return (g > unity) ? unity : g;
	endfunction

endpackage

// ===== rtl/epcg_front.sv =====
`timescale 1ns / 1ps

module epcg_front import epcg_pkg::*; #(
	parameter int SAMPLE_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   armed,
	input  logic [START_W-1:0]     start,
	input  logic [FADE_W-1:0]      fade,
	output ctl_t                   ctl_out,
	output logic [FADE_W-1:0]      dividend
);

	localparam int CW = (SAMPLE_BITS > START_W) ? SAMPLE_BITS : START_W;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic                   before_s2;
	logic [CW-1:0]          elapsed_s2;
	ctl_t                   ctl_s3;
	logic [FADE_W-1:0]      dividend_s3;

	logic [CW:0] diff;
	logic        past;
	mode_t       mode_d;

	// borrow of the subtraction is the "before start" flag
	assign diff = {1'b0, CW'(sample_s1)} - {1'b0, CW'(start)};
	assign past = elapsed_s2 >= CW'(fade);

	always_comb begin
		if (before_s2) begin
			mode_d = MODE_IDLE;
		end else if (fade == '0) begin
			mode_d = MODE_JUMP;
		end else if (past) begin
			mode_d = MODE_DONE;
		end else begin
			mode_d = MODE_RAMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_s3   <= '{valid: 1'b0, mode: MODE_IDLE};
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			ctl_s3   <= '{valid: valid_s2, mode: mode_d};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1   <= sample;
			before_s2   <= !armed || diff[CW];
			elapsed_s2  <= diff[CW-1:0];
			dividend_s3 <= elapsed_s2[FADE_W-1:0];
		end
	end

	assign ctl_out  = ctl_s3;
	assign dividend = dividend_s3;

endmodule

// ===== rtl/epcg_div.sv =====
`timescale 1ns / 1ps

module epcg_div import epcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_in,
	input  logic [FADE_W-1:0] dividend,
	input  logic [FADE_W-1:0] divisor,
	output ctl_t              ctl_out,
	output logic [T_BITS-1:0] quotient
);

	// Restoring division of (dividend << T_BITS) by divisor, one quotient
	// bit per stage, MSB first. dividend < divisor holds in ramp mode.
	ctl_t              ctl_s [T_BITS];
	logic [FADE_W-1:0] rem_s [T_BITS];
	logic [T_BITS-1:0] quo_s [T_BITS];

	logic [FADE_W-1:0] rem_in [T_BITS];
	logic [T_BITS-1:0] quo_in [T_BITS];
	logic [FADE_W:0]   shl    [T_BITS];
	logic [FADE_W+1:0] dif    [T_BITS];
	logic [FADE_W-1:0] rem_d  [T_BITS];
	logic [T_BITS-1:0] quo_d  [T_BITS];

	always_comb begin
		rem_in[0] = dividend;
		quo_in[0] = '0;
		for (int k = 1; k < T_BITS; k++) begin
			rem_in[k] = rem_s[k-1];
			quo_in[k] = quo_s[k-1];
		end
		for (int k = 0; k < T_BITS; k++) begin
			shl[k] = {rem_in[k], 1'b0};
			dif[k] = {1'b0, shl[k]} - {2'b00, divisor};
			if (!dif[k][FADE_W+1]) begin
				rem_d[k] = dif[k][FADE_W-1:0];
				quo_d[k] = {quo_in[k][T_BITS-2:0], 1'b1};
			end else begin
				rem_d[k] = shl[k][FADE_W-1:0];
				quo_d[k] = {quo_in[k][T_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < T_BITS; k++) begin
				ctl_s[k] <= '{valid: 1'b0, mode: MODE_IDLE};
			end
		end else if (en) begin
			ctl_s[0] <= ctl_in;
			for (int k = 1; k < T_BITS; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < T_BITS; k++) begin
				rem_s[k] <= rem_d[k];
				quo_s[k] <= quo_d[k];
			end
		end
	end

	assign ctl_out  = ctl_s[T_BITS-1];
	assign quotient = quo_s[T_BITS-1];

	// remainder of a ramp item leaving the last stage is below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[T_BITS-1].valid && ctl_s[T_BITS-1].mode == MODE_RAMP
		|-> rem_s[T_BITS-1] < divisor)
		else $error("divider remainder not below divisor");

endmodule

// ===== rtl/epcg_sine_rom.sv =====
`timescale 1ns / 1ps

module epcg_sine_rom import epcg_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int FRAC  = 15,
	localparam int AW = $clog2(DEPTH + 1),
	localparam int GW = FRAC + 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr,
	output logic [GW-1:0] data
);

	// quarter sine, entry i = sin(i/DEPTH * pi/2), endpoints exact
	localparam logic [GW-1:0] UNITY = {1'b1, {FRAC{1'b0}}};

	logic [GW-1:0] rom_w [DEPTH+1];

	for (genvar i = 0; i <= DEPTH; i++) begin : g_rom
		localparam longint unsigned X = (longint'(i) * HALF_PI_Q30) / DEPTH;
		if (i == 0) begin : g_zero
			assign rom_w[i] = '0;
		end else if (i == DEPTH) begin : g_top
			assign rom_w[i] = UNITY;
		end else begin : g_mid
			assign rom_w[i] = GW'(sine_gain(X, FRAC));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom_w[addr];
		end
	end

endmodule

// ===== rtl/epcg_gain.sv =====
`timescale 1ns / 1ps

module epcg_gain import epcg_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int FRAC  = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_in,
	input  logic [T_BITS-1:0] quotient,
	input  logic              seg_en,
	output ctl_t              ctl_out,
	output res_t              res
);

	localparam int AW  = $clog2(DEPTH + 1);
	localparam int GW  = FRAC + 1;
	localparam int PW  = 2 * GW;
	localparam int QPW = T_BITS + 1 + AW;
	localparam int HPW = QPW + 1;
	localparam logic [GW-1:0] UNITY  = {1'b1, {FRAC{1'b0}}};
	localparam logic [GW-1:0] HALF_U = UNITY >> 1;

	// stage 1: table positions
	ctl_t           ctl_s1;
	logic [QPW-1:0] prodq_s1;
	logic [HPW-1:0] prodh_s1;
	logic           win_s1;
	// stage 2: table reads
	ctl_t           ctl_s2;
	logic           win_s2;
	logic [GW-1:0]  src_s2;
	logic [GW-1:0]  dst_s2;
	logic [GW-1:0]  mid_s2;
	// stage 3: segment scaling
	ctl_t           ctl_s3;
	logic           act_s3;
	logic [GW-1:0]  src_s3;
	logic [GW-1:0]  dst_s3;
	logic [GW-1:0]  mid_s3;
	logic [PW-1:0]  psrc_s3;
	logic [PW-1:0]  pdst_s3;

	logic [T_BITS:0] t;
	logic [AW-1:0]   q;
	logic [AW:0]     h;
	logic [AW:0]     h_ref;
	logic [AW-1:0]   src_a;
	logic [AW-1:0]   mid_a;
	logic            act_d;
	logic [GW-1:0]   atten;

	assign t = (ctl_in.mode == MODE_DONE) ? T_ONE : {1'b0, quotient};

	// nearest table entry; q <= DEPTH and h <= 2*DEPTH by construction
	assign q     = prodq_s1[T_BITS +: AW];
	assign h     = prodh_s1[T_BITS +: AW+1];
	assign h_ref = (AW+1)'(2 * DEPTH) - h;
	assign src_a = AW'(DEPTH) - q;
	assign mid_a = (h <= (AW+1)'(DEPTH)) ? h[AW-1:0] : h_ref[AW-1:0];

	assign act_d = seg_en && win_s2
		&& (ctl_s2.mode == MODE_DONE || ctl_s2.mode == MODE_RAMP);
	assign atten = UNITY - mid_s2;

	epcg_sine_rom #(.DEPTH(DEPTH), .FRAC(FRAC)) u_rom_dst (
		.clk  (clk),
		.en   (en),
		.addr (q),
		.data (dst_s2)
	);

	epcg_sine_rom #(.DEPTH(DEPTH), .FRAC(FRAC)) u_rom_src (
		.clk  (clk),
		.en   (en),
		.addr (src_a),
		.data (src_s2)
	);

	epcg_sine_rom #(.DEPTH(DEPTH), .FRAC(FRAC)) u_rom_mid (
		.clk  (clk),
		.en   (en),
		.addr (mid_a),
		.data (mid_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, mode: MODE_IDLE};
			ctl_s2 <= '{valid: 1'b0, mode: MODE_IDLE};
			ctl_s3 <= '{valid: 1'b0, mode: MODE_IDLE};
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prodq_s1 <= QPW'(t) * QPW'(DEPTH) + QPW'(T_HALF);
			prodh_s1 <= HPW'(t) * HPW'(2 * DEPTH) + HPW'(T_HALF);
			win_s1   <= (t >= T_LOW) && (t <= T_HIGH);
			win_s2   <= win_s1;
			act_s3   <= act_d;
			src_s3   <= src_s2;
			dst_s3   <= dst_s2;
			mid_s3   <= mid_s2;
			psrc_s3  <= PW'(src_s2) * PW'(atten) + PW'(HALF_U);
			pdst_s3  <= PW'(dst_s2) * PW'(atten) + PW'(HALF_U);
		end
	end

	always_comb begin
		res = '0;
		case (ctl_s3.mode) inside
			MODE_IDLE: begin
				res.src = OUT_W'(UNITY);
			end
			MODE_JUMP: begin
				res.dst  = OUT_W'(UNITY);
				res.done = 1'b1;
			end
			MODE_DONE, MODE_RAMP: begin
				res.done   = (ctl_s3.mode == MODE_DONE);
				res.mid    = seg_en ? OUT_W'(mid_s3) : '0;
				res.active = act_s3;
				res.src    = act_s3 ? OUT_W'(psrc_s3 >> FRAC) : OUT_W'(src_s3);
				res.dst    = act_s3 ? OUT_W'(pdst_s3 >> FRAC) : OUT_W'(dst_s3);
			end
		endcase
	end

	assign ctl_out = ctl_s3;

	// a finished fade sits fully on the destination
	a_done_gains: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && ctl_s3.mode == MODE_DONE
		|-> res.src == '0 && res.dst == OUT_W'(UNITY) && !res.active)
		else $error("finished fade with wrong gains");

	// the segment window only opens inside a running fade
	a_window_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && res.active |-> seg_en && ctl_s3.mode == MODE_RAMP)
		else $error("segment window active outside a ramp");

endmodule

// ===== rtl/equal_power_crossfade_gains.sv =====
// Pipeline: an input transfer reaches m_axis through 3 front stages,
//   16 divider stages, 3 gain stages and the output register.
// Throughput: one sample index per cycle while the skid register is empty; the divider
//   retires one quotient bit per stage, so every unit takes a new item each cycle it advances.
// Reset: arst_n clears all valid bits and the configuration registers to 0.
`timescale 1ns / 1ps

module equal_power_crossfade_gains import epcg_pkg::*; #(
	parameter int SAMPLE_BITS      = 48,
	parameter int GAIN_FRAC_BITS   = 15,
	parameter int SINE_TABLE_DEPTH = 256,
	localparam int IN_TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata,
	// sample index in
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_TDW-1:0]   s_axis_tdata,   // sample_index, zero padded
	// gains out
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [3*OUT_W-1:0]  m_axis_tdata,   // source_gain, destination_gain, middle_gain
	output logic [1:0]          m_axis_tuser    // middle_active, fade_done
);

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while no item is
	// in flight (the block does not enforce this), so every pipeline stage reads them directly.
	// ------------------------------------------------------------------
	logic               armed_q;
	logic [START_W-1:0] start_q;
	logic [FADE_W-1:0]  fade_q;
	logic               seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			start_q <= '0;
			fade_q  <= '0;
			seg_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ARMED:   armed_q <= cfg_wdata[0];
				REG_START:   start_q <= cfg_wdata[START_W-1:0];
				REG_FADE:    fade_q  <= cfg_wdata[FADE_W-1:0];
				REG_SEGMENT: seg_q   <= cfg_wdata[0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline advance. The whole pipe moves while the skid register is
	// empty; a stalled output costs one slot in the skid before the pipe
	// holds, so tready is a register output with no path from m_axis_tready.
	// ------------------------------------------------------------------
	logic adv;
	logic out_v_q;
	logic skid_v_q;
	logic out_free;

	assign adv           = !skid_v_q;
	assign out_free      = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;

	// front: range check, elapsed samples, mode select
	ctl_t              front_ctl;
	logic [FADE_W-1:0] front_dividend;

	epcg_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_axis_tvalid),
		.sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.armed    (armed_q),
		.start    (start_q),
		.fade     (fade_q),
		.ctl_out  (front_ctl),
		.dividend (front_dividend)
	);

	// progress t = elapsed * 2^16 / fade_length
	ctl_t              div_ctl;
	logic [T_BITS-1:0] div_quo;

	epcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_in   (front_ctl),
		.dividend (front_dividend),
		.divisor  (fade_q),
		.ctl_out  (div_ctl),
		.quotient (div_quo)
	);

	// sine lookups and segment attenuation
	ctl_t gain_ctl;
	res_t gain_res;

	epcg_gain #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(GAIN_FRAC_BITS)) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_in   (div_ctl),
		.quotient (div_quo),
		.seg_en   (seg_q),
		.ctl_out  (gain_ctl),
		.res      (gain_res)
	);

	// ------------------------------------------------------------------
	// Output register plus one-entry skid.
	// ------------------------------------------------------------------
	res_t out_q;
	res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (out_free) begin
			out_v_q <= gain_ctl.valid;
		end else if (gain_ctl.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (out_free) begin
			out_q <= gain_res;
		end else if (gain_ctl.valid) begin
			skid_q <= gain_res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_q.mid, out_q.dst, out_q.src};
	assign m_axis_tuser  = {out_q.done, out_q.active};

	// the skid only ever holds an item behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item while output register is empty");

endmodule

// ===== tb/tb_equal_power_crossfade_gains.sv =====
`timescale 1ns / 1ps

module tb_equal_power_crossfade_gains import epcg_pkg::*;;

	localparam int FRAC_W       = 15;
	localparam int TAB_DEPTH    = 256;
	localparam int PIPE_LATENCY = 23;        // front, divider, gain and output stages
	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
	localparam int HANG_LIMIT   = 3000;      // cycles with no transfer at all
	localparam int PRINT_CAP    = 100;

	localparam longint unsigned UNITY_G  = 64'd1 << FRAC_W;
	localparam longint unsigned T_FULL   = 64'd1 << 16;
	localparam longint unsigned WIN_LO   = 64'd6554;
	localparam longint unsigned WIN_HI   = 64'd58982;
	localparam longint unsigned PI2_Q30  = 64'd1686629713;
	localparam logic [47:0]     SAMPLE_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [23:0]     FADE_MAX   = 24'hFF_FFFF;

	typedef struct {
		logic [15:0] src;
		logic [15:0] dst;
		logic [15:0] mid;
		logic        active;
		logic        done;
	} gain_set_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [47:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [3*OUT_W-1:0]  m_axis_tdata;
	logic [1:0]          m_axis_tuser;

	// shadow of the block's registers
	logic                armed_q;
	logic [47:0]         start_q;
	logic [23:0]         fade_q;
	logic                seg_q;

	longint unsigned     sine_tab [0:TAB_DEPTH];
	gain_set_t           expected_gains [$];
	int                  error_count;
	int                  result_count;
	int                  src_idle_pct;
	int                  snk_idle_pct;
	logic                hold_active = 1'b0;
	event                begin_hold;
	int                  quiet_cycles;

	equal_power_crossfade_gains DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Gain prediction
	// ---------------------------------------------------------------

	// sin(x), x in Q30, odd Taylor terms to x^17 with truncating products
	function automatic longint unsigned sin_q30(input longint unsigned x);
		longint unsigned sq;
		longint unsigned term;
		longint          acc;
		sq   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		return (acc < 0) ? 64'd0 : longint'(acc);
	endfunction

	// quarter-sine ROM in Q1.15, rounded half up, end points exact
	task automatic build_sine_tab();
		longint unsigned s;
		longint unsigned g;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			s = sin_q30(longint'(i) * PI2_Q30 / TAB_DEPTH);
			g = (s + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
			sine_tab[i] = (g > UNITY_G) ? UNITY_G : g;
		end
		sine_tab[0]         = 0;
		sine_tab[TAB_DEPTH] = UNITY_G;
	endtask

	function automatic longint unsigned duck_gain(input longint unsigned g,
		input longint unsigned seg);
		return (g * (UNITY_G - seg) + (UNITY_G >> 1)) >> FRAC_W;
	endfunction

	function automatic gain_set_t predict_gains(input logic [47:0] sample);
		gain_set_t       r;
		longint unsigned src, dst, mid;
		longint unsigned elapsed, t, q, h;
		logic            act, fin;
		src = UNITY_G; dst = 0; mid = 0; act = 1'b0; fin = 1'b0;
		if (armed_q && sample >= start_q) begin
			if (fade_q == 0) begin
				// zero length: jump straight to the destination
				src = 0;
				dst = UNITY_G;
				fin = 1'b1;
			end else begin
				elapsed = longint'(sample) - longint'(start_q);
				if (elapsed >= longint'(fade_q)) begin
					t   = T_FULL;
					fin = 1'b1;
				end else begin
					t = (elapsed << 16) / longint'(fade_q);
				end
				q = (t * TAB_DEPTH + (T_FULL >> 1)) >> 16;
				if (q > TAB_DEPTH) q = TAB_DEPTH;
				dst = sine_tab[q];
				src = sine_tab[TAB_DEPTH - q];
				if (seg_q) begin
					h = (t * 2 * TAB_DEPTH + (T_FULL >> 1)) >> 16;
					if (h > 2 * TAB_DEPTH) h = 2 * TAB_DEPTH;
					mid = (h <= TAB_DEPTH) ? sine_tab[h] : sine_tab[2 * TAB_DEPTH - h];
					if (t >= WIN_LO && t <= WIN_HI) begin
						act = 1'b1;
						src = duck_gain(src, mid);
						dst = duck_gain(dst, mid);
					end
				end
			end
		end
		r.src    = src[15:0];
		r.dst    = dst[15:0];
		r.mid    = mid[15:0];
		r.active = act;
		r.done   = fin;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Mismatch reporting and result checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		gain_set_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_gains.size() == 0) begin
				report_mismatch($sformatf("result %0d with no pending sample", result_count));
			end else begin
				want = expected_gains.pop_front();
				if (m_axis_tdata[15:0] !== want.src)
					report_mismatch($sformatf("result %0d source_gain %0d, want %0d",
						result_count, m_axis_tdata[15:0], want.src));
				if (m_axis_tdata[31:16] !== want.dst)
					report_mismatch($sformatf("result %0d destination_gain %0d, want %0d",
						result_count, m_axis_tdata[31:16], want.dst));
				if (m_axis_tdata[47:32] !== want.mid)
					report_mismatch($sformatf("result %0d middle_gain %0d, want %0d",
						result_count, m_axis_tdata[47:32], want.mid));
				if (m_axis_tuser[0] !== want.active)
					report_mismatch($sformatf("result %0d middle_active %b, want %b",
						result_count, m_axis_tuser[0], want.active));
				if (m_axis_tuser[1] !== want.done)
					report_mismatch($sformatf("result %0d fade_done %b, want %b",
						result_count, m_axis_tuser[1], want.done));
			end
			result_count++;
		end
	end

	// ---------------------------------------------------------------
	// Receiver side: random stalls, plus a long hold-off on request
	// ---------------------------------------------------------------

	always @(negedge clk) begin
		if (hold_active)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	initial begin
		forever begin
			@(begin_hold);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_active <= 1'b0;
		end
	end

	// watchdog: a run that stops moving transfers is a failure
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", HANG_LIMIT);
			$display("equal_power_crossfade_gains regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic set_idle(input int src_pct, input int snk_pct);
		@(negedge clk);
		src_idle_pct <= src_pct;
		snk_idle_pct <= snk_pct;
	endtask

	// register write; junk above the field width must be dropped
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= sel;
		cfg_wdata <= value;
		case (sel)
			REG_ARMED:   armed_q = value[0];
			REG_START:   start_q = value[47:0];
			REG_FADE:    fade_q  = value[23:0];
			REG_SEGMENT: seg_q   = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic armed, input logic [47:0] start,
		input logic [23:0] fade, input logic seg);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		write_reg(REG_ARMED,   {junk[46:0], armed});
		write_reg(REG_START,   start);
		write_reg(REG_FADE,    {junk[47:24], fade});
		write_reg(REG_SEGMENT, {junk[63:17], seg});
	endtask

	// one transfer on the input; tvalid stays high into the next call
	task automatic send_sample(input logic [47:0] sample);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sample;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_gains.push_back(predict_gains(sample));
	endtask

	task automatic end_stream();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// every sample yields a result, so an empty queue means idle;
	// an extra wait covers the pipeline anyway
	task automatic wait_drained();
		while (expected_gains.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [47:0] rand_sample48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	// mostly inside or just around the fade window, some anywhere
	function automatic logic [47:0] pick_sample();
		int          sel;
		logic [47:0] off;
		sel = $urandom_range(99);
		if (sel < 70) begin
			off = 48'($urandom_range(int'(fade_q) + 8));
			return start_q + off - 48'd4;
		end else if (sel < 85) begin
			return start_q + 48'($urandom_range(6)) - 48'd3;
		end else begin
			return rand_sample48();
		end
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// registers at reset: not armed, so unity source whatever the index
	task automatic test_reset_state();
		armed_q = 1'b0; start_q = '0; fade_q = '0; seg_q = 1'b0;
		send_sample(48'd0);
		send_sample(SAMPLE_MAX);
		send_sample(48'h5555_5555_5555);
		end_stream();
		wait_drained();
	endtask

	// window edges, clamp, zero length, extremes of every field
	task automatic test_boundaries();
		// fade of 65536 makes t equal to the elapsed count
		load_config(1'b1, 48'd1000, 24'd65536, 1'b1);
		send_sample(48'd999);                     // before start
		send_sample(48'd1000);                    // t = 0
		send_sample(48'd1000 + 48'd6553);         // just below window
		send_sample(48'd1000 + 48'd6554);         // window opens
		send_sample(48'd1000 + 48'd32768);        // half way
		send_sample(48'd1000 + 48'd58982);        // window closes
		send_sample(48'd1000 + 48'd58983);        // just past window
		send_sample(48'd1000 + 48'd65535);        // last ramp sample
		send_sample(48'd1000 + 48'd65536);        // progress reaches one
		send_sample(SAMPLE_MAX);                  // long after
		end_stream();
		wait_drained();
		// segment disabled at the window opening and half way
		write_reg(REG_SEGMENT, '0);
		send_sample(48'd1000 + 48'd32768);
		send_sample(48'd1000 + 48'd6554);
		end_stream();
		wait_drained();
		// zero fade length jumps straight over
		load_config(1'b1, 48'd77, 24'd0, 1'b1);
		send_sample(48'd76);
		send_sample(48'd77);
		send_sample(SAMPLE_MAX);
		end_stream();
		wait_drained();
		// widest start and fade
		load_config(1'b1, SAMPLE_MAX, FADE_MAX, 1'b1);
		send_sample(SAMPLE_MAX);
		send_sample(48'd0);
		end_stream();
		wait_drained();
		write_reg(REG_START, 48'd0);
		send_sample(48'd0);
		send_sample(48'(FADE_MAX) - 48'd1);
		send_sample(48'(FADE_MAX));
		send_sample(48'h80_0000);
		end_stream();
		wait_drained();
		// disarmed after a full setup
		write_reg(REG_ARMED, '0);
		send_sample(48'h80_0000);
		end_stream();
		wait_drained();
	endtask

	// several random settings, each followed by a burst of samples
	task automatic test_random_traffic(input int n_items);
		int          done_items;
		int          burst;
		logic [47:0] start;
		logic [23:0] fade;
		done_items = 0;
		while (done_items < n_items) begin
			case ($urandom_range(4))
				0: start = 48'd0;
				1: start = SAMPLE_MAX - 48'($urandom_range(200));
				2: start = rand_sample48();
				default: start = 48'($urandom_range(1000));
			endcase
			case ($urandom_range(9))
				0: fade = 24'd0;
				1: fade = 24'd1;
				2: fade = FADE_MAX;
				3: fade = 24'($urandom());
				default: fade = 24'($urandom_range(300, 1));
			endcase
			load_config($urandom_range(9) != 0, start, fade, 1'($urandom_range(1)));
			burst = $urandom_range(30, 10);
			for (int i = 0; i < burst; i++)
				send_sample(pick_sample());
			done_items += burst;
			end_stream();
			wait_drained();
		end
	endtask

	// receiver holds off long enough to fill the pipe and stall input;
	// then the sender pauses until everything has come back
	task automatic test_backpressure();
		load_config(1'b1, 48'd5000, 24'd40, 1'b1);
		-> begin_hold;
		for (int i = 0; i < 60; i++)
			send_sample(48'd4998 + 48'($urandom_range(44)));
		end_stream();
		wait_drained();
		for (int i = 0; i < 40; i++)
			send_sample(pick_sample());
		end_stream();
		wait_drained();
	endtask

	initial begin
		error_count  = 0;
		result_count = 0;
		src_idle_pct = 14;
		snk_idle_pct = 79;
		quiet_cycles = 0;
		build_sine_tab();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_boundaries();
		test_random_traffic(120);
		set_idle(79, 14);
		test_random_traffic(120);
		set_idle(0, 0);
		test_random_traffic(120);
		test_backpressure();

		wait_drained();
		if (expected_gains.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_gains.size()));
		if (error_count == 0)
			$display("equal_power_crossfade_gains regression: pass");
		else
			$display("equal_power_crossfade_gains regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/epcg_pkg.sv
rtl/epcg_front.sv
rtl/epcg_div.sv
rtl/epcg_sine_rom.sv
rtl/epcg_gain.sv
rtl/equal_power_crossfade_gains.sv
tb/tb_equal_power_crossfade_gains.sv
